### src/tgf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgf_pkg - shared types and constants of the tanh grading function
// Fixed-point widths, CORDIC angle and shift tables, stage record types.
// ----------------------------------------------------------------------------
package tgf_pkg;

   localparam int A_W        = 36;          // tanh argument, Q32
   localparam int K_BITS     = 5;           // multiples of ln2 in an argument
   localparam int XY_W       = 34;          // CORDIC x, y, z (signed)
   localparam int DEN_W      = XY_W + 1;    // tanh ratio numerator and denominator
   localparam int QT_W       = 31;          // tanh result, Q30 up to 1.0
   localparam int N_W        = 46;          // rounded quotient numerator
   localparam int LIM_W      = 47;          // saturation threshold
   localparam int QD_W       = 16;          // final quotient bits
   localparam int REM_W      = 31;          // final divider remainder
   localparam int ANGLE_N    = 33;
   localparam int STEP_MAX   = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   localparam logic [31:0] LN2_Q32   = 32'hB17217F8;
   localparam logic [15:0] ONE_Q15   = 16'h8000;
   localparam logic [16:0] FRAC_ONE  = 17'h10000;
   localparam logic [15:0] G_MAX     = 16'hFFFF;
   localparam logic [16:0] LIM_MULT  = 17'd32769;
   localparam logic [15:0] LOW_RST   = 16'd4096;
   localparam logic [15:0] HIGH_RST  = 16'd4096;

   localparam logic [CSR_IDX_W-1:0] CSR_GRADING_LOW      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRADING_HIGH     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRADING_FRACTION = 2'd2;

   typedef logic [31:0] angle_tab_type [ANGLE_N];
   typedef logic [5:0]  shift_tab_type [STEP_MAX];

   typedef struct packed {
      logic [A_W-1:0]    rem;
      logic [K_BITS-1:0] k;
      logic              zero;
   } red_type;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [XY_W-1:0] z;
      logic [K_BITS-1:0]      k;
      logic                   zero;
   } rot_type;

   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [DEN_W-1:0] den;
      logic [QT_W-1:0]  q;
   } tdiv_type;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [15:0]      nlo;
      logic [REM_W-1:0] den;
      logic [QD_W-1:0]  q;
      logic             ovf;
   } qdiv_type;

   // shift-and-subtract quotient, used only while building tables
   function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // atanh(2^-i) in Q32 from its odd power series, rounded to nearest
   function automatic angle_tab_type build_angles();
      angle_tab_type tab;
      logic [63:0]   sum;
      logic [63:0]   odd;
      tab[0] = '0;
      for (int i = 1; i < ANGLE_N; i++) begin
         sum = '0;
         for (int k = 0; k < 32; k++) begin
            odd = 64'(2 * k + 1);
            if (odd * 64'(i) <= 64'd62) begin
               sum = sum + div_u64(64'd1 << (64'd62 - odd * 64'(i)), odd);
            end
         end
         tab[i] = 32'((sum + (64'd1 << 29)) >> 30);
      end
      return tab;
   endfunction

   // shift per iteration: 1, 2, 3, 4, 4, 5, ... 13, 13, 14, ...
   function automatic shift_tab_type build_shifts();
      shift_tab_type tab;
      int            i;
      logic          rep;
      i   = 1;
      rep = 1'b0;
      for (int n = 0; n < STEP_MAX; n++) begin
         tab[n] = 6'(i);
         if ((i == 4 || i == 13) && !rep) begin
            rep = 1'b1;
         end else begin
            i   = i + 1;
            rep = 1'b0;
         end
      end
      return tab;
   endfunction

   localparam angle_tab_type ATANH_TAB = build_angles();
   localparam shift_tab_type SHIFT_TAB = build_shifts();

   function automatic int tanh_latency(int steps);
      return K_BITS + steps + 1 + QT_W;
   endfunction

endpackage

### src/tgf_tanh.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgf_tanh - pipelined fixed-point tanh
// ln2 range reduction, hyperbolic CORDIC, then a restoring divider for
// (1-E)/(1+E). One stage per reduction bit, CORDIC step and quotient bit.
// ----------------------------------------------------------------------------
module tgf_tanh
   import tgf_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
) (
   input  logic            clock,
   input  logic            adv,
   input  logic [A_W-1:0]  arg_in,    // Q32, non-negative
   output logic [QT_W-1:0] tanh_out   // Q30
);

   red_type          red_ff [K_BITS];
   red_type          red_in [K_BITS];
   rot_type          rot_ff [CORDIC_STEPS];
   rot_type          rot_in [CORDIC_STEPS];
   logic [DEN_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] den_ff, den_in;
   tdiv_type         div_ff [QT_W];
   tdiv_type         div_in [QT_W];

   function automatic red_type red_step(red_type a, int j);
      red_type        b;
      logic [A_W-1:0] step;
      b    = a;
      step = A_W'(LN2_Q32) << j;
      if (a.rem >= step) begin
         b.rem = a.rem - step;
         b.k   = a.k | (K_BITS'(1) << j);
      end
      return b;
   endfunction

   function automatic rot_type rot_step(rot_type a, int n);
      rot_type                b;
      logic signed [XY_W-1:0] xs;
      logic signed [XY_W-1:0] ys;
      logic signed [XY_W-1:0] ang;
      b   = a;
      xs  = $signed(a.x) >>> SHIFT_TAB[n];
      ys  = $signed(a.y) >>> SHIFT_TAB[n];
      ang = $signed(XY_W'(ATANH_TAB[SHIFT_TAB[n]]));
      if (!a.z[XY_W-1]) begin
         b.x = a.x + ys;
         b.y = a.y + xs;
         b.z = a.z - ang;
      end else begin
         b.x = a.x - ys;
         b.y = a.y - xs;
         b.z = a.z + ang;
      end
      return b;
   endfunction

   function automatic tdiv_type tdiv_step(tdiv_type a, logic first);
      tdiv_type       b;
      logic [DEN_W:0] r2;
      logic           qbit;
      b  = a;
      r2 = first ? {1'b0, a.rem} : {a.rem, 1'b0};
      if (r2 >= {1'b0, a.den}) begin
         b.rem = DEN_W'(r2 - {1'b0, a.den});
         qbit  = 1'b1;
      end else begin
         b.rem = DEN_W'(r2);
         qbit  = 1'b0;
      end
      b.q = {a.q[QT_W-2:0], qbit};
      return b;
   endfunction

   // range reduction: a = k*ln2 + r
   always_comb begin
      red_type seed;
      seed.rem  = arg_in;
      seed.k    = '0;
      seed.zero = (arg_in == '0);
      red_in[0] = red_step(seed, K_BITS - 1);
      for (int s = 1; s < K_BITS; s++) begin
         red_in[s] = red_step(red_ff[s-1], K_BITS - 1 - s);
      end
   end

   // rotation mode, x starts at 1.0 in Q30 and y at zero
   always_comb begin
      rot_type seed;
      seed.x    = XY_W'(1) << 30;
      seed.y    = '0;
      seed.z    = $signed(XY_W'(red_ff[K_BITS-1].rem[31:0]));
      seed.k    = red_ff[K_BITS-1].k;
      seed.zero = red_ff[K_BITS-1].zero;
      rot_in[0] = rot_step(seed, 0);
      for (int n = 1; n < CORDIC_STEPS; n++) begin
         rot_in[n] = rot_step(rot_ff[n-1], n);
      end
   end

   // E = 2^-2k (x-y)/(x+y); form 1-E and 1+E scaled by x+y
   always_comb begin
      logic signed [DEN_W-1:0] sum;
      logic signed [DEN_W-1:0] diff;
      logic [DEN_W-1:0]        p;
      logic [DEN_W-1:0]        m;
      logic [DEN_W-1:0]        em;
      sum  = $signed({rot_ff[CORDIC_STEPS-1].x[XY_W-1], rot_ff[CORDIC_STEPS-1].x})
           + $signed({rot_ff[CORDIC_STEPS-1].y[XY_W-1], rot_ff[CORDIC_STEPS-1].y});
      diff = $signed({rot_ff[CORDIC_STEPS-1].x[XY_W-1], rot_ff[CORDIC_STEPS-1].x})
           - $signed({rot_ff[CORDIC_STEPS-1].y[XY_W-1], rot_ff[CORDIC_STEPS-1].y});
      p  = (sum > 0) ? $unsigned(sum) : DEN_W'(1);
      m  = (diff > 0) ? $unsigned(diff) : '0;
      em = m >> {rot_ff[CORDIC_STEPS-1].k, 1'b0};
      if (em > p) begin
         em = p;
      end
      // zero argument: force a zero numerator, quotient drops to zero
      num_in = rot_ff[CORDIC_STEPS-1].zero ? '0 : (p - em);
      den_in = p + em;
   end

   always_comb begin
      tdiv_type seed;
      seed.rem  = num_ff;
      seed.den  = den_ff;
      seed.q    = '0;
      div_in[0] = tdiv_step(seed, 1'b1);
      for (int t = 1; t < QT_W; t++) begin
         div_in[t] = tdiv_step(div_ff[t-1], 1'b0);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         red_ff <= red_in;
         rot_ff <= rot_in;
         num_ff <= num_in;
         den_ff <= den_in;
         div_ff <= div_in;
      end
   end

   assign tanh_out = div_ff[QT_W-1].q;

endmodule

### src/tanh_grading_function.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tanh_grading_function - one-sided tanh stretching of a unit coordinate
// y = 1 - tanh(g*(1-x))/tanh(g), with g interpolated between two bounds.
// ----------------------------------------------------------------------------
//
//  channel   dir  ports              beat contents
//  --------  ---  -----------------  ---------------------------------------
//  request   in   req_t*             coord_in, unsigned Q1.15
//  response  out  rsp_t*             graded_out, unsigned Q1.15
//  config    in   csr_wen/index/...  grading_low, grading_high, fraction
//
//  One beat enters per cycle while the response side is not stalled; each
//  result passes the front stages, the two tanh pipelines and the final
//  restoring divider.
//  Reset is synchronous, clears the valid bits and reloads the grading
//  registers; req_tready stays low while reset is high.
//  A stall on rsp freezes every stage in place, so nothing drops or repeats.
// ----------------------------------------------------------------------------
module tanh_grading_function
   import tgf_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,    // [15:0] coord_in
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,    // [15:0] graded_out
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int TANH_LAT = tanh_latency(CORDIC_STEPS);
   localparam int DEPTH    = 3 + TANH_LAT + 1 + QD_W + 1;

   // configuration
   logic [15:0] low_ff;
   logic [15:0] high_ff;
   logic [16:0] frac_ff;

   // pipeline control: one valid bit per stage, the last one is rsp_tvalid
   logic [DEPTH-1:0] vld_ff, vld_in;
   logic             adv;

   // front stages
   logic [32:0]     plo_ff, plo_in;
   logic [32:0]     phi_ff, phi_in;
   logic [15:0]     w1_ff, w1_in;
   logic [15:0]     g_ff, g_in;
   logic [15:0]     w2_ff;
   logic [A_W-1:0]  a1_ff, a1_in;
   logic [A_W-1:0]  a2_ff, a2_in;
   logic [QT_W-1:0] t1, t2;

   // final rounded division
   logic [N_W-1:0]   n_ff, n_in;
   logic [LIM_W-1:0] lim_ff, lim_in;
   logic [QT_W-1:0]  t2_ff, t2_in;
   qdiv_type         qd_ff [QD_W];
   qdiv_type         qd_in [QD_W];
   logic [15:0]      y_ff, y_in;

   // advance whenever the output slot is free or being drained
   assign adv        = !vld_ff[DEPTH-1] || rsp_tready;
   assign req_tready = adv && !reset;
   assign rsp_tvalid = vld_ff[DEPTH-1];
   assign rsp_tdata  = y_ff;
   assign vld_in     = {vld_ff[DEPTH-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // register writes, unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= LOW_RST;
         high_ff <= HIGH_RST;
         frac_ff <= '0;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_GRADING_LOW:      low_ff  <= csr_wdata[15:0];
            CSR_GRADING_HIGH:     high_ff <= csr_wdata[15:0];
            CSR_GRADING_FRACTION: frac_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage 1: clamp fraction and coordinate, weight both bounds
   always_comb begin
      logic [16:0] f;
      logic [15:0] x;
      f      = (frac_ff > FRAC_ONE) ? FRAC_ONE : frac_ff;
      x      = (req_tdata > ONE_Q15) ? ONE_Q15 : req_tdata;
      plo_in = 33'(low_ff) * 33'(FRAC_ONE - f);
      phi_in = 33'(high_ff) * 33'(f);
      w1_in  = ONE_Q15 - x;
   end

   // stage 2: round g to Q4.12 and hold it at one LSB or more
   always_comb begin
      logic [33:0] gsum;
      logic [17:0] gq;
      gsum = 34'(plo_ff) + 34'(phi_ff) + 34'(ONE_Q15);
      gq   = gsum[33:16];
      if (gq == '0) begin
         g_in = 16'd1;
      end else if (gq > 18'(G_MAX)) begin
         g_in = G_MAX;
      end else begin
         g_in = gq[15:0];
      end
   end

   // stage 3: both tanh arguments in Q32
   assign a1_in = A_W'({32'(g_ff) * 32'(w2_ff), 5'b0});
   assign a2_in = A_W'({g_ff, 20'b0});

   always_ff @(posedge clock) begin
      if (adv) begin
         plo_ff <= plo_in;
         phi_ff <= phi_in;
         w1_ff  <= w1_in;
         g_ff   <= g_in;
         w2_ff  <= w1_ff;
         a1_ff  <= a1_in;
         a2_ff  <= a2_in;
      end
   end

   tgf_tanh #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_tanh_arg (
      .clock    (clock),
      .adv      (adv),
      .arg_in   (a1_ff),
      .tanh_out (t1)
   );

   tgf_tanh #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_tanh_norm (
      .clock    (clock),
      .adv      (adv),
      .arg_in   (a2_ff),
      .tanh_out (t2)
   );

   // stage 4: rounded numerator and the saturation threshold 32769*t2
   always_comb begin
      t2_in  = (t2 == '0) ? QT_W'(1) : t2;
      n_in   = N_W'({t1, 15'b0}) + N_W'(t2_in >> 1);
      lim_in = LIM_W'(t2_in) * LIM_W'(LIM_MULT);
   end

   function automatic qdiv_type qdiv_step(qdiv_type a, int j);
      qdiv_type       b;
      logic [REM_W:0] r2;
      logic           qbit;
      b  = a;
      r2 = {a.rem, a.nlo[j]};
      if (r2 >= {1'b0, a.den}) begin
         b.rem = REM_W'(r2 - {1'b0, a.den});
         qbit  = 1'b1;
      end else begin
         b.rem = REM_W'(r2);
         qbit  = 1'b0;
      end
      b.q = {a.q[QD_W-2:0], qbit};
      return b;
   endfunction

   // long division, one quotient bit per stage; the top bits seed the remainder
   always_comb begin
      qdiv_type seed;
      seed.rem = REM_W'(n_ff >> 16);
      seed.nlo = n_ff[15:0];
      seed.den = t2_ff;
      seed.q   = '0;
      seed.ovf = ({1'b0, n_ff} >= lim_ff);
      qd_in[0] = qdiv_step(seed, QD_W - 1);
      for (int s = 1; s < QD_W; s++) begin
         qd_in[s] = qdiv_step(qd_ff[s-1], QD_W - 1 - s);
      end
   end

   // quotient past one saturates the result to zero
   assign y_in = qd_ff[QD_W-1].ovf ? '0 : (ONE_Q15 - qd_ff[QD_W-1].q);

   always_ff @(posedge clock) begin
      if (adv) begin
         n_ff   <= n_in;
         lim_ff <= lim_in;
         t2_ff  <= t2_in;
         qd_ff  <= qd_in;
         y_ff   <= y_in;
      end
   end

endmodule

### sim/tb_tanh_grading_function.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tanh_grading_function - self-checking bench for the tanh grading function
// Drives coordinates under several grading settings, predicts each graded
// value with a bit-exact fixed-point model of its own and checks every beat.
// ----------------------------------------------------------------------------
module tb_tanh_grading_function
   import tgf_pkg::*;
();

   localparam int STEPS          = 16;
   localparam int LATENCY        = 74;
   localparam int SETTLE_CYCLES  = LATENCY + 30;
   localparam int CYCLE_LIMIT    = 400000;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam longint unsigned LN2_FIX = 64'hB17217F8;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [15:0]           req_tdata;    // [15:0] coord_in
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [15:0]           rsp_tdata;    // [15:0] graded_out
   logic                  csr_wen;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // predictor copy of the grading registers
   logic [15:0] grade_low;
   logic [15:0] grade_high;
   logic [16:0] grade_frac;

   longint unsigned atanh_q32 [ANGLE_N];
   logic [15:0]     graded_expected [$];
   int              mismatch_count;
   int              send_idle_pct;
   int              recv_idle_pct;
   longint          cycle_count = 0;

   tanh_grading_function #(
      .CORDIC_STEPS(STEPS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // fill the atanh(2^-i) angles, Q32, from the odd power series
   task automatic fill_angles();
      longint unsigned sum;
      longint unsigned odd;
      atanh_q32[0] = 0;
      for (int i = 1; i < ANGLE_N; i++) begin
         sum = 0;
         for (int k = 0; (2 * k + 1) * i <= 62; k++) begin
            odd = longint'(2 * k + 1);
            sum += (64'd1 << (62 - (2 * k + 1) * i)) / odd;
         end
         atanh_q32[i] = (sum + (64'd1 << 29)) >> 30;
      end
   endtask

   // tanh of a non-negative Q32 argument, Q30 result
   function automatic longint unsigned tanh_fix(longint unsigned arg);
      longint unsigned k, r, p, m, em, num, den;
      longint          x, y, z, xs, ys, ang;
      int              i, sh;
      bit              rep;
      if (arg == 0) return 0;
      k   = arg / LN2_FIX;
      r   = arg - k * LN2_FIX;
      x   = 64'sd1 << 30;
      y   = 0;
      z   = longint'(r);
      i   = 1;
      rep = 1'b0;
      for (int n = 0; n < STEPS; n++) begin
         if (i >= ANGLE_N) break;
         xs  = x >>> i;
         ys  = y >>> i;
         ang = longint'(atanh_q32[i]);
         if (z >= 0) begin
            x += ys; y += xs; z -= ang;
         end else begin
            x -= ys; y -= xs; z += ang;
         end
         if ((i == 4 || i == 13) && !rep) begin
            rep = 1'b1;
         end else begin
            i++;
            rep = 1'b0;
         end
      end
      p   = (x + y > 0) ? longint'(x + y) : 1;
      m   = (x - y > 0) ? longint'(x - y) : 0;
      sh  = int'(2 * k);
      em  = (sh < 63) ? (m >> sh) : 0;
      if (em > p) em = p;
      num = p - em;
      den = p + em;
      return (num << 30) / den;
   endfunction

   // graded value 1 - tanh(g*(1-x))/tanh(g) for the current registers
   function automatic logic [15:0] grade_coord(logic [15:0] coord);
      longint unsigned f, g, x, w, t1, t2, q;
      f = (grade_frac > FRAC_ONE) ? 65536 : grade_frac;
      g = (longint'(grade_low) * (65536 - f) + longint'(grade_high) * f + 32768) >> 16;
      if (g < 1) g = 1;
      if (g > 65535) g = 65535;
      x = (coord > ONE_Q15) ? 32768 : coord;
      w = 32768 - x;
      t1 = tanh_fix((g * w) << 5);
      t2 = tanh_fix(g << 20);
      if (t2 == 0) t2 = 1;
      q = ((t1 << 15) + (t2 >> 1)) / t2;
      return (q > 32768) ? 16'd0 : 16'(32768 - q);
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // send one coordinate beat; the expectation is queued when it is accepted
   task automatic send_coord(logic [15:0] coord);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = coord;
      do @(posedge clock); while (!req_tready);
      graded_expected.push_back(grade_coord(coord));
   endtask

   // drop valid, drain every pending result, then let the pipe settle
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (graded_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_wen   = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_wen = 1'b0;
      // only known indexes land in the predictor
      case (idx)
         CSR_GRADING_LOW:      grade_low  = val[15:0];
         CSR_GRADING_HIGH:     grade_high = val[15:0];
         CSR_GRADING_FRACTION: grade_frac = val;
         default: ;
      endcase
   endtask

   task automatic set_grading(logic [15:0] lo, logic [15:0] hi, logic [16:0] fr);
      wait_idle();
      write_csr(CSR_GRADING_LOW, 17'(lo));
      write_csr(CSR_GRADING_HIGH, 17'(hi));
      write_csr(CSR_GRADING_FRACTION, fr);
   endtask

   // coordinate extremes under the reset grading, including two above unity
   task automatic test_coord_extremes();
      logic [15:0] pts [8] = '{16'd0, 16'd1, 16'd16384, 16'h7FFF,
                               ONE_Q15, 16'h8001, 16'hFFFF, 16'h5555};
      foreach (pts[j]) send_coord(pts[j]);
   endtask

   // grading corner settings: zero bounds, reversed bounds, fraction at and past one
   task automatic test_grading_corners();
      set_grading(16'd0, 16'd0, 17'd0);
      send_coord(16'd0); send_coord(16'd12000);
      set_grading(16'd65535, 16'd1, 17'd32768);
      send_coord(16'd100); send_coord(16'd30000);
      set_grading(16'd1, 16'd65535, FRAC_ONE);
      send_coord(16'd1); send_coord(16'd20000);
      set_grading(16'd2048, 16'd40000, 17'h1FFFF);
      send_coord(16'd5000); send_coord(ONE_Q15);
      set_grading(16'd1, 16'd1, 17'd0);
      send_coord(16'd0); send_coord(16'd32767);
      // unknown index must leave the grading untouched
      wait_idle();
      write_csr(CSR_UNUSED, 17'h1ABCD);
      send_coord(16'd8192); send_coord(16'd24576);
   endtask

   function automatic logic [15:0] random_coord();
      int pick;
      pick = $urandom_range(99);
      if (pick < 70) return 16'($urandom_range(32768));
      if (pick < 80) return $urandom_range(1) ? 16'($urandom_range(8)) :
                                                16'($urandom_range(32768, 32760));
      return 16'($urandom_range(65535));
   endfunction

   // random coordinates under a fresh random grading per block
   task automatic test_random_phase(int snd, int rcv, int count);
      int f_pick;
      send_idle_pct = snd;
      recv_idle_pct = rcv;
      for (int b = 0; b < count / 50; b++) begin
         f_pick = $urandom_range(3);
         set_grading(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                     (f_pick == 0) ? 17'd0 : (f_pick == 1) ? FRAC_ONE :
                     17'($urandom_range(131071)));
         repeat (50) send_coord(random_coord());
      end
   endtask

   // receiver: change ready at the falling edge
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // check each accepted result beat against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (graded_expected.size() == 0) begin
            report_mismatch("unexpected result beat", rsp_tdata, 16'd0);
         end else begin
            if (rsp_tdata !== graded_expected[0])
               report_mismatch("graded_out", rsp_tdata, graded_expected[0]);
            void'(graded_expected.pop_front());
         end
      end
   end

   // hard stop on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tanh_grading_function verification failed");
         $finish;
      end
   end

   initial begin
      mismatch_count = 0;
      send_idle_pct  = 0;
      recv_idle_pct  = 0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_wen    = 1'b0;
      csr_index  = CSR_GRADING_LOW;
      csr_wdata  = '0;
      grade_low  = LOW_RST;
      grade_high = HIGH_RST;
      grade_frac = '0;
      fill_angles();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_coord_extremes();
      test_grading_corners();
      test_random_phase(33, 71, 300);
      test_random_phase(71, 33, 300);
      test_random_phase(0, 0, 300);
      wait_idle();

      if (mismatch_count == 0 && graded_expected.size() == 0) begin
         $display("tanh_grading_function verification clean");
      end else begin
         $display("tanh_grading_function verification failed");
      end
      $finish;
   end

endmodule
